// ===== rtl/rgbg_pkg.sv =====
// rgbg_pkg: shared types, register codes and gain helper for the gain/blend block
// used by rgbg_cfg, rgbg_lane and rgb_channel_gain_blend
package rgbg_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned SLIDER_W = 14;
  localparam int unsigned GAIN_W   = 22;
  localparam int unsigned PROD_W   = CHAN_W + GAIN_W;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [SLIDER_W-1:0] UNITY_SLIDER = 14'd4096;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN   = 22'd65536;
  // 256*4096 - 65536, the offset of the upper gain segment
  localparam logic [GAIN_W-1:0]   UPPER_OFFSET = 22'd983040;

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_AVG     = 2'd2,
    MODE_SPARE   = 2'd3
  } mix_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_CHAN0_SLIDER = 3'd1,
    REG_CHAN1_SLIDER = 3'd2,
    REG_CHAN2_SLIDER = 3'd3,
    REG_MIX_MODE     = 3'd4,
    REG_EXCLUDE_ON   = 3'd5,
    REG_EXCLUDE_RGB  = 3'd6,
    REG_EXCLUDE_DIST = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                              enable;
    logic [NUM_CHAN-1:0][GAIN_W-1:0]   gain;
    mix_mode_t                         mix_mode;
    logic                              exclude_on;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]   exclude_rgb;
    logic [CHAN_W-1:0]                 exclude_dist;
  } cfg_t;

  typedef struct packed {
    logic      load;
    mix_mode_t mode;
  } lane_ctl_t;

  // 16*s below unity, 256*s - 983040 at and above unity
  function automatic logic [GAIN_W-1:0] gain_of(input logic [SLIDER_W-1:0] s);
    logic [GAIN_W-1:0] lo;
    logic [GAIN_W-1:0] hi;
    lo = {4'd0, s, 4'd0};
    hi = {s, 8'd0} - UPPER_OFFSET;
    return (s < UNITY_SLIDER) ? lo : hi;
  endfunction

endpackage

// ===== rtl/rgbg_cfg.sv =====
// rgbg_cfg: configuration register file, sliders stored as ready-made gains
// depends on rgbg_pkg
module rgbg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [rgbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_data,
  output rgbg_pkg::cfg_t                 cfg
);
  import rgbg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable       <= 1'b1;
      cfg.gain         <= {NUM_CHAN{UNITY_GAIN}};
      cfg.mix_mode     <= MODE_REPLACE;
      cfg.exclude_on   <= 1'b0;
      cfg.exclude_rgb  <= '0;
      cfg.exclude_dist <= 8'd16;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:       cfg.enable       <= cfg_data[0];
        REG_CHAN0_SLIDER: cfg.gain[0]      <= gain_of(cfg_data[SLIDER_W-1:0]);
        REG_CHAN1_SLIDER: cfg.gain[1]      <= gain_of(cfg_data[SLIDER_W-1:0]);
        REG_CHAN2_SLIDER: cfg.gain[2]      <= gain_of(cfg_data[SLIDER_W-1:0]);
        REG_MIX_MODE:     cfg.mix_mode     <= mix_mode_t'(cfg_data[1:0]);
        REG_EXCLUDE_ON:   cfg.exclude_on   <= cfg_data[0];
        REG_EXCLUDE_RGB:  cfg.exclude_rgb  <= cfg_data[NUM_CHAN*CHAN_W-1:0];
        REG_EXCLUDE_DIST: cfg.exclude_dist <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/rgbg_lane.sv =====
// rgbg_lane: one color channel, registered gain multiply then clamp and blend
// depends on rgbg_pkg
module rgbg_lane (
  input  logic                        clk,
  input  rgbg_pkg::lane_ctl_t         ctl,
  input  logic [rgbg_pkg::CHAN_W-1:0] chan_in,
  input  logic [rgbg_pkg::GAIN_W-1:0] gain,
  output logic [rgbg_pkg::CHAN_W-1:0] chan_out
);
  import rgbg_pkg::*;

  logic [PROD_W-FRAC_W-1:0] scaled;
  logic [CHAN_W-1:0]        src;
  logic [PROD_W-1:0]        prod;
  logic [CHAN_W-1:0]        clamped;
  logic [CHAN_W:0]          sum;

  assign prod = PROD_W'(chan_in) * PROD_W'(gain);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      scaled <= prod[PROD_W-1:FRAC_W];
      src    <= chan_in;
    end
  end

  // anything above 255 saturates
  assign clamped = (|scaled[PROD_W-FRAC_W-1:CHAN_W]) ? '1 : scaled[CHAN_W-1:0];
  assign sum     = {1'b0, src} + {1'b0, clamped};

  always_comb begin
    case (ctl.mode)
      MODE_ADD: chan_out = sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
      MODE_AVG: chan_out = sum[CHAN_W:1];
      default:  chan_out = clamped;
    endcase
  end

endmodule

// ===== rtl/rgb_channel_gain_blend.sv =====
// rgb_channel_gain_blend: top level, per-channel gain with saturation and blend
// depends on rgbg_pkg, rgbg_cfg, rgbg_lane
// throughput: one word per cycle while m_tready is high; stage 3 is
//   the output register, each stage loads whenever it is empty or
//   the next stage moves on
// reset: synchronous, clears all valid bits and restores register defaults
//   (enable 1, unity gains, replace mode, exclusion off, distance 16)
module rgb_channel_gain_blend (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,  // [31:0] pixel_in
  input  logic                           s_tuser,  // [0] skip_frame
  input  logic                           s_tlast,  // last_in_frame
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,  // [31:0] pixel_out
  output logic                           m_tlast,  // last_out
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rgbg_pkg::*;

  cfg_t cfg;

  // stage valid bits and per-stage readiness
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  // stage 1: captured pixel and pass-through decision
  logic [31:0] pix1;
  logic        byp1;
  logic        last1;
  // stage 2: products live in the lanes, pixel and flags travel here
  logic [31:0] pix2;
  logic        byp2;
  logic        last2;

  logic        near;
  logic        byp_next;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] blended;
  logic [31:0] pix_next;
  lane_ctl_t   lane_ctl;

  assign cfg_ready = 1'b1;

  rgbg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a stage takes a new word when empty or when its word moves forward
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // near test: every channel within exclude_dist of the reference color
  always_comb begin
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] d;
    near = 1'b1;
    for (int k = 0; k < NUM_CHAN; k++) begin
      a = s_tdata[k*CHAN_W +: CHAN_W];
      b = cfg.exclude_rgb[k];
      d = (a > b) ? (a - b) : (b - a);
      if (d > cfg.exclude_dist) near = 1'b0;
    end
  end

  // disabled block, skipped frame or excluded color all pass unchanged
  assign byp_next = !cfg.enable || s_tuser || (cfg.exclude_on && near);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) begin
      pix1  <= s_tdata;
      byp1  <= byp_next;
      last1 <= s_tlast;
    end
    if (v1 && rdy2) begin
      pix2  <= pix1;
      byp2  <= byp1;
      last2 <= last1;
    end
    if (v2 && rdy3) begin
      m_tdata <= pix_next;
      m_tlast <= last2;
    end
  end

  // lanes register their product with stage 2 and blend on the way to stage 3
  assign lane_ctl.load = v1 && rdy2;
  assign lane_ctl.mode = cfg.mix_mode;

  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    rgbg_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .chan_in  (pix1[k*CHAN_W +: CHAN_W]),
      .gain     (cfg.gain[k]),
      .chan_out (blended[k])
    );
  end

  // replace keeps source alpha, additive and average clear it
  always_comb begin
    logic [CHAN_W-1:0] alpha;
    alpha = (cfg.mix_mode == MODE_ADD || cfg.mix_mode == MODE_AVG) ? '0 : pix2[31:24];
    pix_next = byp2 ? pix2 : {alpha, blended[2], blended[1], blended[0]};
  end

  assign m_tvalid = v3;

endmodule

// ===== rtl/rgbg_checker.sv =====
// rgbg_checker: port-level assertions for rgb_channel_gain_blend, bound to the top
// depends on nothing but the top level's ports
module rgbg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // words accepted but not yet delivered
  logic [2:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 3'd3)
    else $error("more words in flight than pipeline stages");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> in_flight != 3'd0)
    else $error("output word with nothing accepted");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output stage is empty");

endmodule

bind rgb_channel_gain_blend rgbg_checker u_rgbg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
